FILE: hdl/nth_weekday_of_month_defines.svh
// Assertion macros used by the nth_weekday_of_month checker.
`ifndef NTH_WEEKDAY_OF_MONTH_DEFINES_SVH
`define NTH_WEEKDAY_OF_MONTH_DEFINES_SVH

// Check a property on every clock edge, skipping cycles in reset.
`define NWM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define NWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/nwm_pkg.sv
// Package: codes, calendar tables and helper functions for the weekday finder.
`timescale 1ns / 1ps

package nwm_pkg;

   // Field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int KIND_W  = 3;
   localparam int WDAY_W  = 3;
   localparam int DAY_W   = 5;

   // Shifted year (year + 400 - 1 for Jan/Feb) and day-of-week sum widths
   localparam int YY_W    = 15;
   localparam int SUM_W   = 15;

   // Reciprocal for division by 100: floor(n * 5243 / 2^19) is exact below 43690
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int PYY_W        = YY_W + 13;
   localparam int PY_W         = YEAR_W + 13;
   localparam int Q100_W       = 8;

   localparam logic [YY_W-1:0]   YEAR_BIAS = YY_W'(400);
   localparam logic [DAY_W-1:0]  DAY_TEENTH_ANCHOR = DAY_W'(13);
   localparam logic [DAY_W-1:0]  DAY_FIRST_ANCHOR  = DAY_W'(1);

   // Week kind codes
   localparam logic [KIND_W-1:0] WK_FIRST  = 3'd0;
   localparam logic [KIND_W-1:0] WK_SECOND = 3'd1;
   localparam logic [KIND_W-1:0] WK_THIRD  = 3'd2;
   localparam logic [KIND_W-1:0] WK_FOURTH = 3'd3;
   localparam logic [KIND_W-1:0] WK_LAST   = 3'd4;
   localparam logic [KIND_W-1:0] WK_TEENTH = 3'd5;

   // Weekday and month limits
   localparam logic [WDAY_W-1:0]  WD_SATURDAY = 3'd6;
   localparam logic [MONTH_W-1:0] MON_JAN     = 4'd1;
   localparam logic [MONTH_W-1:0] MON_FEB     = 4'd2;
   localparam logic [MONTH_W-1:0] MON_MAR     = 4'd3;
   localparam logic [MONTH_W-1:0] MON_DEC     = 4'd12;

   // Length of a common-year month; unused codes give 31
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] d;
      case (m)
         4'd2:                      d = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
         default:                   d = 5'd31;
      endcase
      return d;
   endfunction

   // Month offset of the day-of-week formula; unused codes give 0
   function automatic logic [2:0] month_shift(input logic [MONTH_W-1:0] m);
      logic [2:0] s;
      case (m)
         4'd2:  s = 3'd3;
         4'd3:  s = 3'd2;
         4'd4:  s = 3'd5;
         4'd6:  s = 3'd3;
         4'd7:  s = 3'd5;
         4'd8:  s = 3'd1;
         4'd9:  s = 3'd4;
         4'd10: s = 3'd6;
         4'd11: s = 3'd2;
         4'd12: s = 3'd4;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

   // Residue modulo 7 by folding octal digits (8 is 1 mod 7)
   function automatic logic [2:0] mod7(input logic [SUM_W-1:0] s);
      logic [5:0] x;
      logic [3:0] t;
      x = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
      t = 4'(x[5:3]) + 4'(x[2:0]);
      if (t >= 4'd7) begin
         t = t - 4'd7;
      end
      return t[2:0];
   endfunction

   // Reduce a value up to 13 modulo 7
   function automatic logic [2:0] mod7_small(input logic [3:0] v);
      logic [3:0] t;
      t = v;
      if (t >= 4'd7) begin
         t = t - 4'd7;
      end
      return t[2:0];
   endfunction

endpackage

FILE: hdl/nth_weekday_of_month.sv
// Top level: four-stage pipeline that finds the nth weekday of a month.
//
//   channel | direction | ports                                         | handshake
//   req     | in        | req_year, req_month, req_week_kind, req_weekday | req_valid/req_ready
//   rsp     | out       | rsp_day_of_month, rsp_input_error             | rsp_valid/rsp_ready
//
// One transfer in per cycle, one result out per cycle, while rsp is not stalled.
// Stages: reciprocal products for /100, day-of-week sum, mod-7 fold, day select.
// Synchronous active-high reset clears the valid bits only.
// A stall on rsp freezes every stage at once; req_ready drops in the same cycle.
`timescale 1ns / 1ps

module nth_weekday_of_month
   import nwm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [YEAR_W-1:0]  req_year,
   input  logic [MONTH_W-1:0] req_month,
   input  logic [KIND_W-1:0]  req_week_kind,
   input  logic [WDAY_W-1:0]  req_weekday,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [DAY_W-1:0]   rsp_day_of_month,
   output logic               rsp_input_error
);

   logic advance;

   // Stage 1: products for division by 100
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_err_ff, s1_err_in;
   logic [YEAR_W-1:0]  s1_year_ff;
   logic [YY_W-1:0]    s1_yy_ff, s1_yy_in;
   logic [MONTH_W-1:0] s1_month_ff;
   logic [KIND_W-1:0]  s1_kind_ff;
   logic [WDAY_W-1:0]  s1_want_ff;
   logic [PYY_W-1:0]   s1_pyy_ff, s1_pyy_in;
   logic [PY_W-1:0]    s1_py_ff, s1_py_in;

   // Stage 2: day-of-week sum
   logic               s2_valid_ff;
   logic               s2_err_ff;
   logic [SUM_W-1:0]   s2_sum_ff, s2_sum_in;
   logic [DAY_W-1:0]   s2_last_ff, s2_last_in;
   logic [KIND_W-1:0]  s2_kind_ff;
   logic [WDAY_W-1:0]  s2_want_ff;

   // Stage 3: weekday of the anchor date
   logic               s3_valid_ff;
   logic               s3_err_ff;
   logic [2:0]         s3_dow_ff, s3_dow_in;
   logic [DAY_W-1:0]   s3_last_ff;
   logic [KIND_W-1:0]  s3_kind_ff;
   logic [WDAY_W-1:0]  s3_want_ff;

   // Stage 4: result
   logic               s4_valid_ff;
   logic               s4_err_ff;
   logic [DAY_W-1:0]   s4_day_ff, s4_day_in;

   // Stage 2 intermediates
   logic [Q100_W-1:0]  q100;
   logic [Q100_W-1:0]  yq100;
   logic [YEAR_W-1:0]  year_rem;
   logic               leap;
   logic [DAY_W-1:0]   anchor2;

   // Stage 4 intermediates
   logic [2:0]         r_last;
   logic [2:0]         r_fwd;
   logic [DAY_W-1:0]   anchor4;
   logic [DAY_W-1:0]   week_add;

   // Advance the whole pipe when the output is empty or being taken
   assign advance   = !s4_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Stage 1 logic: flag bad codes, shift the year, start /100
   always_comb begin
      s1_valid_in = req_valid;
      s1_err_in   = (req_month < MON_JAN) || (req_month > MON_DEC)
                 || (req_week_kind > WK_TEENTH) || (req_weekday > WD_SATURDAY);
      s1_yy_in    = YY_W'(req_year) + YEAR_BIAS - ((req_month < MON_MAR) ? YY_W'(1) : YY_W'(0));
      s1_pyy_in   = PYY_W'(s1_yy_in) * PYY_W'(DIV100_MUL);
      s1_py_in    = PY_W'(req_year) * PY_W'(DIV100_MUL);
   end

   // Stage 2 logic: leap year, month length, anchor and weekday sum
   always_comb begin
      q100     = Q100_W'(s1_pyy_ff >> DIV100_SHIFT);
      yq100    = Q100_W'(s1_py_ff >> DIV100_SHIFT);
      year_rem = s1_year_ff - YEAR_W'(yq100) * YEAR_W'(100);
      leap     = (s1_year_ff[1:0] == 2'b00) && ((year_rem != '0) || (yq100[1:0] == 2'b00));
      s2_last_in = month_len(s1_month_ff)
                 + (((s1_month_ff == MON_FEB) && leap) ? DAY_W'(1) : DAY_W'(0));
      if (s1_kind_ff == WK_LAST) begin
         anchor2 = s2_last_in;
      end else if (s1_kind_ff == WK_TEENTH) begin
         anchor2 = DAY_TEENTH_ANCHOR;
      end else begin
         anchor2 = DAY_FIRST_ANCHOR;
      end
      s2_sum_in = s1_yy_ff + (s1_yy_ff >> 2) - SUM_W'(q100) + SUM_W'(q100 >> 2)
                + SUM_W'(month_shift(s1_month_ff)) + SUM_W'(anchor2);
   end

   // Stage 3 logic: fold the sum down to a weekday
   assign s3_dow_in = mod7(s2_sum_ff);

   // Stage 4 logic: step from the anchor to the wanted weekday
   always_comb begin
      r_last   = mod7_small(4'(s3_dow_ff) + 4'd7 - 4'(s3_want_ff));
      r_fwd    = mod7_small(4'(s3_want_ff) + 4'd7 - 4'(s3_dow_ff));
      anchor4  = (s3_kind_ff == WK_TEENTH) ? DAY_TEENTH_ANCHOR : DAY_FIRST_ANCHOR;
      week_add = (DAY_W'(s3_kind_ff) << 3) - DAY_W'(s3_kind_ff);
      if (s3_err_ff) begin
         s4_day_in = '0;
      end else if (s3_kind_ff == WK_LAST) begin
         s4_day_in = s3_last_ff - DAY_W'(r_last);
      end else if (s3_kind_ff <= WK_FOURTH) begin
         s4_day_in = anchor4 + DAY_W'(r_fwd) + week_add;
      end else begin
         s4_day_in = anchor4 + DAY_W'(r_fwd);
      end
   end

   // Valid bits: clear on reset, shift when the pipe advances
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers: hold on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_err_ff   <= s1_err_in;
         s1_year_ff  <= req_year;
         s1_yy_ff    <= s1_yy_in;
         s1_month_ff <= req_month;
         s1_kind_ff  <= req_week_kind;
         s1_want_ff  <= req_weekday;
         s1_pyy_ff   <= s1_pyy_in;
         s1_py_ff    <= s1_py_in;

         s2_err_ff   <= s1_err_ff;
         s2_sum_ff   <= s2_sum_in;
         s2_last_ff  <= s2_last_in;
         s2_kind_ff  <= s1_kind_ff;
         s2_want_ff  <= s1_want_ff;

         s3_err_ff   <= s2_err_ff;
         s3_dow_ff   <= s3_dow_in;
         s3_last_ff  <= s2_last_ff;
         s3_kind_ff  <= s2_kind_ff;
         s3_want_ff  <= s2_want_ff;

         s4_err_ff   <= s3_err_ff;
         s4_day_ff   <= s4_day_in;
      end
   end

   assign rsp_valid        = s4_valid_ff;
   assign rsp_day_of_month = s4_day_ff;
   assign rsp_input_error  = s4_err_ff;

endmodule

FILE: hdl/nwm_checker.sv
// Port-level checker for nth_weekday_of_month and its bind statement.
`timescale 1ns / 1ps
`include "nth_weekday_of_month_defines.svh"

module nwm_checker
   import nwm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [YEAR_W-1:0]  req_year,
   input logic [MONTH_W-1:0] req_month,
   input logic [KIND_W-1:0]  req_week_kind,
   input logic [WDAY_W-1:0]  req_weekday,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DAY_W-1:0]   rsp_day_of_month,
   input logic               rsp_input_error
);

   // Hold a stalled result
   `NWM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_day_of_month) && $stable(rsp_input_error), "rsp changed while stalled")

   // Drive day zero exactly with an error
   `NWM_ASSERT(a_err_day, clock, reset, rsp_valid |-> (rsp_input_error == (rsp_day_of_month == '0)), "error flag and day disagree")

   // Drop input acceptance while the output is stalled
   `NWM_ASSERT(a_stall_back, clock, reset, rsp_valid && !rsp_ready |-> !req_ready, "req taken during output stall")

   // Leave reset with no valid result on rsp
   `NWM_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "rsp valid right after reset")

endmodule

bind nth_weekday_of_month nwm_checker u_nwm_checker (.*);
